// File: rtl/core/i2cbm_pkg.sv
// Package for the I2C bit-level master: command codes, step limits and
// the word format that travels from the front end through the queue.
// No dependencies.
package i2cbm_pkg;

  // Depth of the queue between front end and step engine
  localparam int unsigned QUEUE_DEPTH = 2;

  // Mode codes on the input channel; MODE_TICK doubles as the idle command
  localparam logic [2:0] MODE_TICK  = 3'd0;
  localparam logic [2:0] MODE_START = 3'd1;
  localparam logic [2:0] MODE_STOP  = 3'd2;
  localparam logic [2:0] MODE_SEND  = 3'd3;
  localparam logic [2:0] MODE_RECV  = 3'd4;
  localparam logic [2:0] MODE_SACK  = 3'd5;
  localparam logic [2:0] MODE_RACK  = 3'd6;

  localparam int unsigned BITS_PER_BYTE = 8;

  // Step index of the final SCL-low step of a byte transfer
  localparam logic [4:0] SEND_LAST_STEP = 5'(3 * BITS_PER_BYTE - 1);
  localparam logic [4:0] RECV_LAST_STEP = 5'(3 * BITS_PER_BYTE);

  // Phase within one bit slot: data, SCL high, SCL low
  localparam logic [1:0] PH_DATA = 2'd0;
  localparam logic [1:0] PH_HIGH = 2'd1;
  localparam logic [1:0] PH_LOW  = 2'd2;

  // Classified input word
  typedef enum logic [1:0] {
    OP_TICK,
    OP_CMD,
    OP_NOP
  } op_kind_e;

  typedef struct packed {
    op_kind_e   kind;
    logic [2:0] cmd;
    logic [7:0] tx_byte;
    logic       ack_bit;
    logic       sda_in;
  } op_t;

  // Write side of the queue
  typedef struct packed {
    logic valid;
    op_t  op;
  } q_wr_t;

  // Read side of the queue
  typedef struct packed {
    logic valid;
    op_t  op;
  } q_rd_t;

endpackage

// File: rtl/core/i2cbm_if.sv
// Channel interfaces of the I2C bit-level master: input word and result word,
// each with valid/ready handshake. No dependencies.
interface i2cbm_in_if;
  logic       valid;
  logic       ready;
  logic [2:0] mode;
  logic [7:0] tx_byte;
  logic       ack_bit;
  logic       sda_in;

  modport source (output valid, mode, tx_byte, ack_bit, sda_in, input ready);
  modport sink   (input valid, mode, tx_byte, ack_bit, sda_in, output ready);
endinterface

interface i2cbm_out_if;
  logic       valid;
  logic       ready;
  logic       scl_drive;
  logic       sda_drive;
  logic       busy_res;
  logic       done_res;
  logic [7:0] rx_byte;
  logic       rx_ack;
  logic       rejected;

  modport source (output valid, scl_drive, sda_drive, busy_res, done_res, rx_byte,
                  rx_ack, rejected, input ready);
  modport sink   (input valid, scl_drive, sda_drive, busy_res, done_res, rx_byte,
                  rx_ack, rejected, output ready);
endinterface

// File: rtl/core/i2cbm_front.sv
// Front end: takes input words and classifies them into tick, command or no-op.
// Depends on i2cbm_pkg and i2cbm_in_if.
module i2cbm_front (
  i2cbm_in_if.sink          in_i,
  output i2cbm_pkg::q_wr_t  wr_o,
  input  logic              wr_ready_i
);
  import i2cbm_pkg::*;

  op_t op;

  // Classify by mode; the reserved code passes through as a no-op
  always_comb begin
    op.cmd     = in_i.mode;
    op.tx_byte = in_i.tx_byte;
    op.ack_bit = in_i.ack_bit;
    op.sda_in  = in_i.sda_in;
    case (in_i.mode)
      MODE_TICK: op.kind = OP_TICK;
      MODE_START, MODE_STOP, MODE_SEND, MODE_RECV, MODE_SACK, MODE_RACK: begin
        op.kind = OP_CMD;
      end
      default: op.kind = OP_NOP;
    endcase
  end

  assign wr_o.valid  = in_i.valid;
  assign wr_o.op     = op;
  assign in_i.ready  = wr_ready_i;

endmodule

// File: rtl/core/i2cbm_queue.sv
// Small FIFO of classified words between front end and step engine.
// Depends on i2cbm_pkg.
module i2cbm_queue #(
  parameter int unsigned Depth = i2cbm_pkg::QUEUE_DEPTH
) (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  i2cbm_pkg::q_wr_t           wr_i,
  output logic                       wr_ready_o,
  output i2cbm_pkg::q_rd_t           rd_o,
  input  logic                       rd_ready_i,
  output logic [$clog2(Depth+1)-1:0] count_o
);
  import i2cbm_pkg::*;

  localparam int unsigned AW = (Depth > 1) ? $clog2(Depth) : 1;
  localparam int unsigned CW = $clog2(Depth + 1);

  op_t             mem_q [Depth];
  logic [AW-1:0]   wr_ptr_q, wr_ptr_d;
  logic [AW-1:0]   rd_ptr_q, rd_ptr_d;
  logic [CW-1:0]   count_q, count_d;
  logic            push, pop;

  assign wr_ready_o = (count_q != CW'(Depth));
  assign push       = wr_i.valid && wr_ready_o;
  assign pop        = (count_q != '0) && rd_ready_i;

  // Pointer and fill count update with wrap at Depth
  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    count_d  = count_q;
    if (push) begin
      wr_ptr_d = (wr_ptr_q == AW'(Depth - 1)) ? '0 : wr_ptr_q + AW'(1);
    end
    if (pop) begin
      rd_ptr_d = (rd_ptr_q == AW'(Depth - 1)) ? '0 : rd_ptr_q + AW'(1);
    end
    case ({push, pop})
      2'b10:   count_d = count_q + CW'(1);
      2'b01:   count_d = count_q - CW'(1);
      default: count_d = count_q;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      count_q  <= count_d;
    end
  end

  // Storage
  always_ff @(posedge clk_i) begin
    if (push) begin
      mem_q[wr_ptr_q] <= wr_i.op;
    end
  end

  assign rd_o.valid = (count_q != '0);
  assign rd_o.op    = mem_q[rd_ptr_q];
  assign count_o    = count_q;

endmodule

// File: rtl/core/i2cbm_back.sv
// Step engine: runs one queued word per cycle against the bus state unless out_o
// stalls, and registers the result word. Depends on i2cbm_pkg and i2cbm_out_if.
module i2cbm_back (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  i2cbm_pkg::q_rd_t  rd_i,
  output logic              rd_ready_o,
  i2cbm_out_if.source       out_o
);
  import i2cbm_pkg::*;

  // Engine state
  logic [2:0] cmd_q, cmd_d;
  logic [4:0] step_q, step_d;
  logic [1:0] phase_q, phase_d;
  logic [7:0] tx_q, tx_d;
  logic [7:0] rx_q, rx_d;
  logic       ack_q, ack_d;
  logic       scl_q, scl_d;
  logic       sda_q, sda_d;
  logic       sack_q, sack_d;

  // Result register
  logic       out_valid_q, out_valid_d;
  logic       o_scl_q, o_sda_q, o_busy_q, o_done_q, o_rack_q, o_rej_q;
  logic [7:0] o_rx_q;

  logic       pop, busy, done, rej, last;
  logic [1:0] phase_nx;

  assign rd_ready_o = !out_valid_q || out_o.ready;
  assign pop        = rd_i.valid && rd_ready_o;
  assign busy       = (cmd_q != MODE_TICK);
  assign phase_nx   = (phase_q == PH_LOW) ? PH_DATA : phase_q + 2'd1;

  // One word: a tick steps a running command, a command is latched or rejected
  always_comb begin
    cmd_d   = cmd_q;
    step_d  = step_q;
    phase_d = phase_q;
    tx_d    = tx_q;
    rx_d    = rx_q;
    ack_d   = ack_q;
    scl_d   = scl_q;
    sda_d   = sda_q;
    sack_d  = sack_q;
    done    = 1'b0;
    rej     = 1'b0;
    last    = 1'b0;
    if (pop) begin
      case (rd_i.op.kind)
        OP_TICK: begin
          if (busy) begin
            case (cmd_q)
              MODE_START: begin
                case (step_q)
                  5'd0:    sda_d = 1'b1;
                  5'd1:    scl_d = 1'b1;
                  5'd2:    sda_d = 1'b0;
                  default: begin
                    scl_d = 1'b0;
                    last  = 1'b1;
                  end
                endcase
              end
              MODE_STOP: begin
                case (step_q)
                  5'd0:    sda_d = 1'b0;
                  5'd1:    scl_d = 1'b1;
                  default: begin
                    sda_d = 1'b1;
                    last  = 1'b1;
                  end
                endcase
              end
              MODE_SEND: begin
                phase_d = phase_nx;
                case (phase_q)
                  PH_DATA: begin
                    sda_d = tx_q[7];
                    tx_d  = {tx_q[6:0], 1'b0};
                  end
                  PH_HIGH: scl_d = 1'b1;
                  default: begin
                    scl_d = 1'b0;
                    last  = (step_q >= SEND_LAST_STEP);
                  end
                endcase
              end
              MODE_RECV: begin
                // first step releases SDA, then slots of SCL high, sample, SCL low
                if (step_q == 5'd0) begin
                  sda_d = 1'b1;
                end else begin
                  phase_d = phase_nx;
                  case (phase_q)
                    PH_DATA: scl_d = 1'b1;
                    PH_HIGH: rx_d  = {rx_q[6:0], rd_i.op.sda_in};
                    default: begin
                      scl_d = 1'b0;
                      last  = (step_q >= RECV_LAST_STEP);
                    end
                  endcase
                end
              end
              MODE_SACK: begin
                case (step_q)
                  5'd0:    sda_d = ack_q;
                  5'd1:    scl_d = 1'b1;
                  default: begin
                    scl_d = 1'b0;
                    last  = 1'b1;
                  end
                endcase
              end
              MODE_RACK: begin
                case (step_q)
                  5'd0:    sda_d  = 1'b1;
                  5'd1:    scl_d  = 1'b1;
                  5'd2:    sack_d = rd_i.op.sda_in;
                  default: begin
                    scl_d = 1'b0;
                    last  = 1'b1;
                  end
                endcase
              end
              default: last = 1'b1;
            endcase
            done = last;
            if (last) begin
              cmd_d  = MODE_TICK;
              step_d = '0;
            end else begin
              step_d = step_q + 5'd1;
            end
          end
        end
        OP_CMD: begin
          if (busy) begin
            rej = 1'b1;
          end else begin
            cmd_d   = rd_i.op.cmd;
            step_d  = '0;
            phase_d = PH_DATA;
            if (rd_i.op.cmd == MODE_SEND) tx_d  = rd_i.op.tx_byte;
            if (rd_i.op.cmd == MODE_SACK) ack_d = rd_i.op.ack_bit;
          end
        end
        default: ;
      endcase
    end
  end

  // Result word is held until the receiver takes it
  always_comb begin
    out_valid_d = out_valid_q;
    if (pop) begin
      out_valid_d = 1'b1;
    end else if (out_o.ready) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cmd_q       <= MODE_TICK;
      step_q      <= '0;
      phase_q     <= PH_DATA;
      tx_q        <= '0;
      rx_q        <= '0;
      ack_q       <= 1'b1;
      scl_q       <= 1'b1;
      sda_q       <= 1'b1;
      sack_q      <= 1'b1;
      out_valid_q <= 1'b0;
    end else begin
      cmd_q       <= cmd_d;
      step_q      <= step_d;
      phase_q     <= phase_d;
      tx_q        <= tx_d;
      rx_q        <= rx_d;
      ack_q       <= ack_d;
      scl_q       <= scl_d;
      sda_q       <= sda_d;
      sack_q      <= sack_d;
      out_valid_q <= out_valid_d;
    end
  end

  // Result payload
  always_ff @(posedge clk_i) begin
    if (pop) begin
      o_scl_q  <= scl_d;
      o_sda_q  <= sda_d;
      o_busy_q <= (cmd_d != MODE_TICK);
      o_done_q <= done;
      o_rx_q   <= rx_d;
      o_rack_q <= sack_d;
      o_rej_q  <= rej;
    end
  end

  assign out_o.valid     = out_valid_q;
  assign out_o.scl_drive = o_scl_q;
  assign out_o.sda_drive = o_sda_q;
  assign out_o.busy_res  = o_busy_q;
  assign out_o.done_res  = o_done_q;
  assign out_o.rx_byte   = o_rx_q;
  assign out_o.rx_ack    = o_rack_q;
  assign out_o.rejected  = o_rej_q;

endmodule

// File: rtl/core/i2c_bit_level_master_unit.sv
// I2C bit-level master engine on open-drain pin levels.
//
// Input channel in_i carries words of mode, tx_byte, ack_bit and sda_in.
// Mode 1..6 latches a command (start, stop, send byte, receive byte, send
// ack, receive ack) while idle; a command while busy is flagged rejected.
// Mode 0 is a tick: one pin step of the latched command, with sda_in used
// on sampling steps. Mode 7 is ignored but still answered.
// Output channel out_o returns exactly one result word per input word, in
// order: SCL/SDA drive levels, busy, done, received byte, sampled ack and
// the rejected flag.
// An accepted input word passes through the queue and then the result register;
// throughput is one word per cycle while out_o is not stalled, set by the step
// engine behind the queue.
// A stalled receiver holds the result register; the queue then fills and
// in_i.ready drops once it holds QueueDepth words.
// Reset returns both pins to released, clears the queue and the result valid
// flag, and leaves the engine idle with rx_byte 0 and rx_ack 1.
// Depends on i2cbm_pkg, i2cbm_if, i2cbm_front, i2cbm_queue, i2cbm_back.
module i2c_bit_level_master_unit #(
  parameter int unsigned QueueDepth = i2cbm_pkg::QUEUE_DEPTH
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  i2cbm_in_if.sink    in_i,
  i2cbm_out_if.source out_o
);
  import i2cbm_pkg::*;

  q_wr_t                         wr;
  q_rd_t                         rd;
  logic                          wr_ready;
  logic                          rd_ready;
  logic [$clog2(QueueDepth+1)-1:0] q_count;

  // Classifier
  i2cbm_front u_front (
    .in_i       (in_i),
    .wr_o       (wr),
    .wr_ready_i (wr_ready)
  );

  // Decoupling queue
  i2cbm_queue #(
    .Depth (QueueDepth)
  ) u_queue (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .wr_i       (wr),
    .wr_ready_o (wr_ready),
    .rd_o       (rd),
    .rd_ready_i (rd_ready),
    .count_o    (q_count)
  );

  // Step engine and result register
  i2cbm_back u_back (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .rd_i       (rd),
    .rd_ready_o (rd_ready),
    .out_o      (out_o)
  );

`ifndef ASSERT_OFF
  // Fill count never exceeds the queue depth
  a_q_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    q_count <= ($clog2(QueueDepth+1))'(QueueDepth))
    else $error("queue count above depth");

  // A finishing tick leaves the engine idle
  a_done_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_o.valid && out_o.done_res |-> !out_o.busy_res)
    else $error("done with engine still busy");

  // A rejected command means a command was already running
  a_rej_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_o.valid && out_o.rejected |-> out_o.busy_res && !out_o.done_res)
    else $error("rejected word while idle or done");

  // Nothing leaves the queue while the result register is stalled
  a_stall_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_o.valid && !out_o.ready && rd.valid |=> out_o.valid)
    else $error("result word lost during stall");
`endif

endmodule
